// File: src/thve_pkg.sv
// shared types and constants for the tensor header varint encoder
package thve_pkg;

    localparam int DIM_W  = 31;
    localparam int BPE_W  = 4;
    localparam int LEN_W  = 32;
    localparam int BYTE_W = 8;

    localparam logic [BPE_W-1:0]  BPE_RESET = 4'd4;
    localparam logic [BYTE_W-1:0] DIM_TAG   = 8'h08;
    localparam logic [BYTE_W-1:0] FIX_BYTE0 = 8'h10;
    localparam logic [BYTE_W-1:0] FIX_BYTE1 = 8'h01;
    localparam logic [BYTE_W-1:0] FIX_BYTE2 = 8'h4a;

    // multiply steps of the payload length unit
    typedef enum logic [1:0] {
        MUL_CW   = 2'd0,
        MUL_H    = 2'd1,
        MUL_BPE  = 2'd2,
        MUL_DONE = 2'd3
    } mul_step_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAG,
        ST_VAR,
        ST_FIX0,
        ST_FIX1,
        ST_FIX2,
        ST_PAY
    } state_t;

endpackage

// File: src/thve_len.sv
// payload length unit: one shared 32-bit multiplier stepped three times
module thve_len
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [thve_pkg::DIM_W-1:0]      channel_dim,
    input  logic [thve_pkg::DIM_W-1:0]      width_dim,
    input  logic [thve_pkg::DIM_W-1:0]      height_dim,
    input  logic [thve_pkg::BPE_W-1:0]      bpe,
    output logic [thve_pkg::LEN_W-1:0]      len,
    output logic                            done
);

    thve_pkg::mul_step_t            step_reg;
    thve_pkg::mul_step_t            step_next;
    logic [thve_pkg::LEN_W-1:0]     prod_reg;
    logic [thve_pkg::LEN_W-1:0]     prod_next;
    logic [thve_pkg::LEN_W-1:0]     op_a;
    logic [thve_pkg::LEN_W-1:0]     op_b;
    logic [thve_pkg::LEN_W-1:0]     full;

    always_comb
    begin
        op_a = prod_reg;
        op_b = {{(thve_pkg::LEN_W-thve_pkg::BPE_W){1'b0}}, bpe};
        unique case (step_reg)
            thve_pkg::MUL_CW:
            begin
                op_a = {1'b0, channel_dim};
                op_b = {1'b0, width_dim};
            end
            thve_pkg::MUL_H:
            begin
                op_b = {1'b0, height_dim};
            end
            thve_pkg::MUL_BPE:
            begin
                op_b = {{(thve_pkg::LEN_W-thve_pkg::BPE_W){1'b0}}, bpe};
            end
            thve_pkg::MUL_DONE:
            begin
                op_b = {{(thve_pkg::LEN_W-thve_pkg::BPE_W){1'b0}}, bpe};
            end
            default:
            begin
                op_b = {{(thve_pkg::LEN_W-thve_pkg::BPE_W){1'b0}}, bpe};
            end
        endcase
        full = op_a * op_b;
    end

    always_comb
    begin
        step_next = step_reg;
        prod_next = prod_reg;
        if (start)
        begin
            step_next = thve_pkg::MUL_CW;
        end
        else if (step_reg != thve_pkg::MUL_DONE)
        begin
            // product wraps to 32 bits
            prod_next = full[thve_pkg::LEN_W-1:0];
            step_next = thve_pkg::mul_step_t'(step_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= thve_pkg::MUL_DONE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign len  = prod_reg;
    assign done = (step_reg == thve_pkg::MUL_DONE);

endmodule

// File: src/tensor_header_varint_encoder_unit.sv
// Tensor header varint encoder: one request carries a tensor shape and gives
// a header of 12 to 32 bytes, one byte per cycle while out_stall is low; in_stall
// stays high until the last byte has been loaded into the output register. The
// byte sequencer shifts each value out seven bits per byte. The payload length
// channel*width*height*bytes_per_element is formed by a single 32-bit
// multiplier used three times in the first cycles after acceptance, well
// before the length bytes are due. bytes_per_element is written through
// cfg_wr_en/cfg_wr_data and resets to 4; the user must write it only while the
// block is idle, which the block itself does not enforce.
module tensor_header_varint_encoder_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [thve_pkg::BPE_W-1:0]      cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [thve_pkg::DIM_W-1:0]      batch_dim,
    input  logic [thve_pkg::DIM_W-1:0]      channel_dim,
    input  logic [thve_pkg::DIM_W-1:0]      width_dim,
    input  logic [thve_pkg::DIM_W-1:0]      height_dim,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [thve_pkg::BYTE_W-1:0]     out_byte,
    output logic                            last_byte
);

    thve_pkg::state_t                       state_reg;
    thve_pkg::state_t                       state_next;
    logic [thve_pkg::BPE_W-1:0]             bpe_reg;
    logic [thve_pkg::DIM_W-1:0]             dims_reg [4];
    logic [1:0]                             sel_reg;
    logic [1:0]                             sel_next;
    logic [thve_pkg::LEN_W-1:0]             val_reg;
    logic [thve_pkg::LEN_W-1:0]             val_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [thve_pkg::BYTE_W-1:0]            out_byte_reg;
    logic [thve_pkg::BYTE_W-1:0]            out_byte_next;
    logic                                   last_reg;
    logic                                   last_next;
    logic                                   accept;
    logic                                   advance;
    logic                                   more;
    logic [thve_pkg::LEN_W-1:0]             len;
    logic                                   len_done;

    assign in_stall = (state_reg != thve_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    // output slot is free or being taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign more     = (val_reg[thve_pkg::LEN_W-1:7] != '0);

    thve_len u_len
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .channel_dim (dims_reg[1]),
        .width_dim   (dims_reg[2]),
        .height_dim  (dims_reg[3]),
        .bpe         (bpe_reg),
        .len         (len),
        .done        (len_done)
    );

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = 1'b0;
            last_next      = 1'b0;
            unique case (state_reg)
                thve_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        sel_next   = 2'd0;
                        state_next = thve_pkg::ST_TAG;
                    end
                end
                thve_pkg::ST_TAG:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = thve_pkg::DIM_TAG;
                    val_next       = {1'b0, dims_reg[sel_reg]};
                    state_next     = thve_pkg::ST_VAR;
                end
                thve_pkg::ST_VAR:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {more, val_reg[6:0]};
                    val_next       = val_reg >> 7;
                    if (!more)
                    begin
                        if (sel_reg == 2'd3)
                        begin
                            state_next = thve_pkg::ST_FIX0;
                        end
                        else
                        begin
                            sel_next   = sel_reg + 2'd1;
                            state_next = thve_pkg::ST_TAG;
                        end
                    end
                end
                thve_pkg::ST_FIX0:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = thve_pkg::FIX_BYTE0;
                    state_next     = thve_pkg::ST_FIX1;
                end
                thve_pkg::ST_FIX1:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = thve_pkg::FIX_BYTE1;
                    state_next     = thve_pkg::ST_FIX2;
                end
                thve_pkg::ST_FIX2:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = thve_pkg::FIX_BYTE2;
                    val_next       = len;
                    state_next     = thve_pkg::ST_PAY;
                end
                thve_pkg::ST_PAY:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {more, val_reg[6:0]};
                    val_next       = val_reg >> 7;
                    if (!more)
                    begin
                        last_next  = 1'b1;
                        state_next = thve_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = thve_pkg::ST_IDLE;
                end
            endcase
        end
        else if (accept)
        begin
            sel_next   = 2'd0;
            state_next = thve_pkg::ST_TAG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= thve_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            bpe_reg       <= thve_pkg::BPE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                bpe_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg      <= sel_next;
        val_reg      <= val_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        if (accept)
        begin
            dims_reg[0] <= batch_dim;
            dims_reg[1] <= channel_dim;
            dims_reg[2] <= width_dim;
            dims_reg[3] <= height_dim;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

    // length must be ready before its bytes are shifted out
    a_len_ready : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == thve_pkg::ST_PAY) |-> len_done)
        else $error("payload length not ready");

    // fixed bytes follow only after the height dimension
    a_fix_after_height : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == thve_pkg::ST_FIX0) |-> (sel_reg == 2'd3))
        else $error("fixed bytes before last dimension");

    // a held last byte leaves the sequencer idle or waiting on its first tag
    a_last_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_byte) |->
            (state_reg == thve_pkg::ST_IDLE || state_reg == thve_pkg::ST_TAG))
        else $error("sequencer busy while last byte pending");

endmodule

// File: sim/tensor_header_varint_encoder_unit_tb.sv
// self-checking testbench for the tensor header varint encoder
`timescale 1ns / 1ps

module tensor_header_varint_encoder_unit_tb;

    localparam int CLK_HALF     = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [thve_pkg::DIM_W-1:0] batch;
        logic [thve_pkg::DIM_W-1:0] chan;
        logic [thve_pkg::DIM_W-1:0] wid;
        logic [thve_pkg::DIM_W-1:0] hgt;
    } shape_t;

    typedef struct packed {
        logic [thve_pkg::BYTE_W-1:0] data;
        logic                        last;
    } hdr_byte_t;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [thve_pkg::BPE_W-1:0]  cfg_wr_data = '0;
    logic                        in_valid    = 1'b0;
    logic                        in_stall;
    logic [thve_pkg::DIM_W-1:0]  batch_dim   = '0;
    logic [thve_pkg::DIM_W-1:0]  channel_dim = '0;
    logic [thve_pkg::DIM_W-1:0]  width_dim   = '0;
    logic [thve_pkg::DIM_W-1:0]  height_dim  = '0;
    logic                        out_valid;
    logic                        out_stall   = 1'b0;
    logic [thve_pkg::BYTE_W-1:0] out_byte;
    logic                        last_byte;

    shape_t     shape_q[$];
    hdr_byte_t  hdr_bytes_q[$];
    shape_t     cur_shape;
    logic [thve_pkg::BPE_W-1:0] bpe_now = thve_pkg::BPE_RESET;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         err_count = 0;
    int         idle_cycles = 0;
    int         hold_left = 0;
    logic       hold_kick = 1'b0;

    tensor_header_varint_encoder_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .batch_dim   (batch_dim),
        .channel_dim (channel_dim),
        .width_dim   (width_dim),
        .height_dim  (height_dim),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_byte   (last_byte)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    // seven value bits per byte, continuation bit on all but the final byte
    task automatic push_varint(input logic [thve_pkg::LEN_W-1:0] value,
                               input logic ends_header);
        logic [thve_pkg::LEN_W-1:0] rest;
        hdr_byte_t                  b;
        rest = value;
        do
        begin
            b.data = {1'b0, rest[6:0]};
            rest = rest >> 7;
            b.data[7] = (rest != 0);
            b.last = ends_header && (rest == 0);
            hdr_bytes_q.push_back(b);
        end
        while (rest != 0);
    endtask

    task automatic push_fixed(input logic [thve_pkg::BYTE_W-1:0] data);
        hdr_byte_t b;
        b.data = data;
        b.last = 1'b0;
        hdr_bytes_q.push_back(b);
    endtask

    task automatic build_header(input shape_t s);
        logic [thve_pkg::LEN_W-1:0] payload_len;
        push_fixed(thve_pkg::DIM_TAG);
        push_varint({1'b0, s.batch}, 1'b0);
        push_fixed(thve_pkg::DIM_TAG);
        push_varint({1'b0, s.chan}, 1'b0);
        push_fixed(thve_pkg::DIM_TAG);
        push_varint({1'b0, s.wid}, 1'b0);
        push_fixed(thve_pkg::DIM_TAG);
        push_varint({1'b0, s.hgt}, 1'b0);
        push_fixed(thve_pkg::FIX_BYTE0);
        push_fixed(thve_pkg::FIX_BYTE1);
        push_fixed(thve_pkg::FIX_BYTE2);
        // each product wraps to 32 bits
        payload_len = {1'b0, s.chan} * {1'b0, s.wid};
        payload_len = payload_len * {1'b0, s.hgt};
        payload_len = payload_len
                      * {{(thve_pkg::LEN_W-thve_pkg::BPE_W){1'b0}}, bpe_now};
        push_varint(payload_len, 1'b1);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                build_header(cur_shape);
            if (shape_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cur_shape = shape_q.pop_front();
                in_valid    <= 1'b1;
                batch_dim   <= cur_shape.batch;
                channel_dim <= cur_shape.chan;
                width_dim   <= cur_shape.wid;
                height_dim  <= cur_shape.hgt;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        hdr_byte_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (hdr_bytes_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %02h", out_byte));
                end
                else
                begin
                    want = hdr_bytes_q.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, want.data));
                    if (last_byte !== want.last)
                        report_mismatch($sformatf("last_byte %b, expected %b",
                                                  last_byte, want.last));
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic add_shape(input logic [thve_pkg::DIM_W-1:0] b,
                             input logic [thve_pkg::DIM_W-1:0] c,
                             input logic [thve_pkg::DIM_W-1:0] w,
                             input logic [thve_pkg::DIM_W-1:0] h);
        shape_t s;
        s.batch = b;
        s.chan  = c;
        s.wid   = w;
        s.hgt   = h;
        shape_q.push_back(s);
    endtask

    // spread values over one to five varint bytes, with zero and all-ones now and then
    function automatic logic [thve_pkg::DIM_W-1:0] pick_dim();
        int                         nbytes;
        logic [31:0]                r;
        logic [thve_pkg::DIM_W-1:0] v;
        nbytes = $urandom_range(1, 5);
        r = $urandom;
        v = r[thve_pkg::DIM_W-1:0];
        if (nbytes < 5)
            v = v & ((31'd1 << (7 * nbytes)) - 31'd1);
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++)
            add_shape(pick_dim(), pick_dim(), pick_dim(), pick_dim());
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (shape_q.size() != 0 || in_valid || hdr_bytes_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bpe(input logic [thve_pkg::BPE_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        bpe_now = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 68;

        // directed shapes at the reset value of bytes_per_element
        add_shape('0, '0, '0, '0);
        add_shape('1, '1, '1, '1);
        add_shape(31'd1, 31'd1, 31'd1, 31'd1);
        add_shape(31'd127, 31'd128, 31'd127, 31'd128);
        add_shape(31'd16383, 31'd16384, 31'd2, 31'd3);
        add_shape(31'd2097151, 31'd2097152, 31'd1, 31'd1);
        add_shape(31'd268435455, 31'd268435456, 31'd1, 31'd1);
        add_shape(31'd7, 31'd65536, 31'd65536, 31'd1);
        add_shape(31'd0, 31'd16384, 31'd16384, 31'd4);
        add_shape(31'h55555555, 31'h2aaaaaaa, 31'h55555555, 31'h2aaaaaaa);
        add_shape(31'h2aaaaaaa, 31'h55555555, 31'h2aaaaaaa, 31'h55555555);
        add_shape(31'd3, 31'd0, 31'd5, 31'd9);
        add_shape(31'd128, 31'd1073741824, 31'd1, 31'd1);
        drain();

        write_bpe(4'd0);
        add_shape(31'd1, 31'd100, 31'd100, 31'd100);
        add_shape('1, '1, '1, '1);
        drain();

        // receiver holds off while requests keep coming
        write_bpe(4'd8);
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        add_shape('1, '1, '1, '1);
        add_random(100);
        drain();

        send_idle_pct = 68;
        recv_idle_pct = 29;
        write_bpe(4'd1);
        add_shape('1, '1, '1, '1);
        add_random(100);
        drain();

        write_bpe(4'd15);
        add_random(60);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_bpe(4'd9);
        add_random(60);
        drain();

        write_bpe(4'd3);
        add_random(80);
        drain();

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
